### rtl/spif_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spif_pkg
// Shared types and constants of the SPI port with built-in serial flash.
// ---------------------------------------------------------------------------
package spif_pkg;

   localparam int unsigned IMAGE_DEPTH_DEF = 131072;
   localparam int unsigned PTR_W           = 24;
   localparam int unsigned BYTE_W          = 8;

   // bus function codes
   localparam logic [1:0] FUNC_READ  = 2'd0;
   localparam logic [1:0] FUNC_WRITE = 2'd1;
   localparam logic [1:0] FUNC_LOAD  = 2'd2;

   // register offsets
   localparam logic [1:0] REG_CTRL = 2'd0;
   localparam logic [1:0] REG_DATA = 2'd1;
   localparam logic [1:0] REG_PEEK = 2'd2;

   // device select codes
   localparam logic [2:0] DEV_FLASH  = 3'd1;
   localparam logic [2:0] DEV_SDCARD = 3'd3;
   localparam logic [2:0] DEV_RTC    = 3'd5;
   localparam logic [2:0] DEV_NONE   = 3'd7;

   localparam logic [7:0] CMD_READ  = 8'h03;
   localparam logic [7:0] IDLE_BYTE = 8'hFF;

   typedef enum logic [2:0] {
      PH_CMD      = 3'd0,
      PH_ADDR_HI  = 3'd1,
      PH_ADDR_MID = 3'd2,
      PH_ADDR_LO  = 3'd3,
      PH_STREAM   = 3'd4,
      PH_ERROR    = 3'd5
   } phase_type;

endpackage

### rtl/spif_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spif_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ---------------------------------------------------------------------------
module spif_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/spi_port_with_serial_flash_read.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spi_port_with_serial_flash_read
// Bus-mapped SPI port with a built-in serial flash answering read command 03.
// ---------------------------------------------------------------------------
// One item is taken every clock cycle while the output register is free or
// being drained; each item yields exactly one response item. The flash image
// sits in one RAM with a registered read: a streaming shift issues
// the image read and the byte is folded into the last-byte register in the
// following cycle, so a read of the data or peek register right behind it
// sees the new byte. Image loads write the RAM in the cycle they are taken.
// The image has no reset and needs no clearing pass; bytes never loaded read
// back as unknown. The image index is kept modulo IMAGE_DEPTH alongside the
// 24-bit flash pointer, so any depth works, not only powers of two.
// ---------------------------------------------------------------------------
module spi_port_with_serial_flash_read import spif_pkg::*; #(
   parameter int unsigned IMAGE_DEPTH = IMAGE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [1:0]  req_reg_addr,
   input  logic [7:0]  req_wdata,
   input  logic [16:0] req_load_addr,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_rdata
);

   localparam int unsigned IDX_W = $clog2(IMAGE_DEPTH);
   localparam logic [IDX_W:0]   DEPTH_X  = (IDX_W+1)'(IMAGE_DEPTH);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(IMAGE_DEPTH - 1);

   // shift a byte into a residue modulo the image depth
   function automatic logic [IDX_W-1:0] mod_push8(input logic [IDX_W-1:0] r,
                                                  input logic [7:0] b);
      logic [IDX_W:0] acc;
      acc = {1'b0, r};
      for (int i = 7; i >= 0; i--) begin
         acc = {acc[IDX_W-1:0], b[i]};
         if (acc >= DEPTH_X) begin
            acc = acc - DEPTH_X;
         end
      end
      return acc[IDX_W-1:0];
   endfunction

   phase_type         phase_ff, phase_in;
   logic [2:0]        dev_ff, dev_in;
   logic [PTR_W-1:0]  ptr_ff, ptr_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [7:0]        last_ff, last_in;
   logic              pend_ff, pend_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_rdata_ff, rsp_rdata_in;

   logic              req_fire;
   logic [7:0]        last_cur;
   logic              do_shift;
   logic [7:0]        shift_byte;
   logic              ram_re, ram_we;
   logic [7:0]        ram_q;
   logic [IDX_W:0]    load_hi;
   logic [IDX_W-1:0]  load_idx;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign last_cur  = pend_ff ? ram_q : last_ff;

   // load address reduced modulo the image depth
   always_comb begin
      load_hi = (IDX_W+1)'(req_load_addr[16:8]);
      if (load_hi >= DEPTH_X) begin
         load_hi = load_hi - DEPTH_X;
      end
      load_idx = mod_push8(load_hi[IDX_W-1:0], req_load_addr[7:0]);
   end

   spif_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (IMAGE_DEPTH)
   ) u_image (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (load_idx),
      .wr_data (req_wdata),
      .rd_en   (ram_re),
      .rd_addr (idx_ff),
      .rd_data (ram_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_CMD;
         dev_ff       <= DEV_NONE;
         ptr_ff       <= '0;
         idx_ff       <= '0;
         last_ff      <= IDLE_BYTE;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         dev_ff       <= dev_in;
         ptr_ff       <= ptr_in;
         idx_ff       <= idx_in;
         last_ff      <= last_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_rdata_ff <= rsp_rdata_in;
   end

   always_comb begin
      phase_in     = phase_ff;
      dev_in       = dev_ff;
      ptr_in       = ptr_ff;
      idx_in       = idx_ff;
      last_in      = last_cur;
      pend_in      = 1'b0;
      ram_re       = 1'b0;
      ram_we       = 1'b0;
      do_shift     = 1'b0;
      shift_byte   = '0;
      rsp_rdata_in = rsp_rdata_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (req_fire) begin
         rsp_valid_in = 1'b1;
         rsp_rdata_in = '0;
         case (req_func)
            FUNC_READ: begin
               case (req_reg_addr)
                  REG_CTRL: rsp_rdata_in = {5'b0, dev_ff};
                  REG_DATA: begin
                     rsp_rdata_in = last_cur;
                     do_shift     = 1'b1;
                  end
                  REG_PEEK: rsp_rdata_in = last_cur;
                  default:  rsp_rdata_in = '0;
               endcase
            end
            FUNC_WRITE: begin
               case (req_reg_addr)
                  REG_CTRL: begin
                     if (req_wdata[2:0] != DEV_FLASH) begin
                        phase_in = PH_CMD;
                        ptr_in   = '0;
                        idx_in   = '0;
                        if (req_wdata[2:0] == DEV_SDCARD || req_wdata[2:0] == DEV_RTC) begin
                           dev_in = req_wdata[2:0];
                        end else begin
                           dev_in = DEV_NONE;
                        end
                     end else begin
                        dev_in = DEV_FLASH;
                     end
                  end
                  REG_DATA: begin
                     do_shift   = 1'b1;
                     shift_byte = req_wdata;
                  end
                  default: ;
               endcase
            end
            FUNC_LOAD: ram_we = 1'b1;
            default: ;
         endcase
      end

      if (do_shift) begin
         if (dev_ff == DEV_FLASH) begin
            last_in = '0;
            case (phase_ff)
               PH_CMD: begin
                  phase_in = (shift_byte == CMD_READ) ? PH_ADDR_HI : PH_ERROR;
               end
               PH_ADDR_HI: begin
                  ptr_in   = ptr_ff | {shift_byte, 16'h0000};
                  idx_in   = mod_push8('0, shift_byte);
                  phase_in = PH_ADDR_MID;
               end
               PH_ADDR_MID: begin
                  ptr_in   = ptr_ff | {8'h00, shift_byte, 8'h00};
                  idx_in   = mod_push8(idx_ff, shift_byte);
                  phase_in = PH_ADDR_LO;
               end
               PH_ADDR_LO: begin
                  ptr_in   = ptr_ff | {16'h0000, shift_byte};
                  idx_in   = mod_push8(idx_ff, shift_byte);
                  phase_in = PH_STREAM;
               end
               PH_STREAM: begin
                  ram_re  = 1'b1;
                  pend_in = 1'b1;
                  ptr_in  = ptr_ff + 1'b1;
                  if (ptr_ff == {PTR_W{1'b1}} || idx_ff == IDX_LAST) begin
                     idx_in = '0;
                  end else begin
                     idx_in = idx_ff + 1'b1;
                  end
               end
               default: ;
            endcase
         end else if (dev_ff == DEV_SDCARD || dev_ff == DEV_RTC) begin
            last_in = IDLE_BYTE;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_rdata = rsp_rdata_ff;

   // deselecting the flash always returns it to the command phase
   assert property (@(posedge clock) disable iff (reset)
      req_fire && req_func == FUNC_WRITE && req_reg_addr == REG_CTRL
         && req_wdata[2:0] != DEV_FLASH
      |=> phase_ff == PH_CMD && ptr_ff == '0 && idx_ff == '0)
      else $error("flash not reset on deselect");

   // the image index stays inside the image
   assert property (@(posedge clock) disable iff (reset)
      (IDX_W+1)'(idx_ff) < DEPTH_X)
      else $error("image index out of range");

   // only the device codes are ever selected
   assert property (@(posedge clock) disable iff (reset)
      dev_ff == DEV_FLASH || dev_ff == DEV_SDCARD || dev_ff == DEV_RTC || dev_ff == DEV_NONE)
      else $error("bad device select");

   // writes, loads and the unused function code answer zero
   assert property (@(posedge clock) disable iff (reset)
      req_fire && req_func != FUNC_READ |=> rsp_valid && rsp_rdata == '0)
      else $error("non-read item answered nonzero");

endmodule

### sim/spi_flash_read_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spi_flash_read_checker
// Watches the request and response channels of the SPI port, keeps its own
// copy of the device select, flash phase, pointer, last byte and image, and
// compares every response byte with the byte predicted for the oldest
// accepted item that has not been answered yet.
// ---------------------------------------------------------------------------
module spi_flash_read_checker import spif_pkg::*; #(
   parameter int unsigned IMAGE_DEPTH = IMAGE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [1:0]  req_reg_addr,
   input  logic [7:0]  req_wdata,
   input  logic [16:0] req_load_addr,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [7:0]  rsp_rdata,
   output int unsigned outstanding,
   output int unsigned fail_count
);

   logic [7:0]  image_bytes [IMAGE_DEPTH];
   logic [2:0]  cur_device;
   phase_type   cur_phase;
   logic [23:0] cur_pointer;
   logic [7:0]  last_byte;
   logic [7:0]  expected_rdata [$];
   logic [7:0]  oldest_rdata;

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      $display("%0t mismatch: %s, rdata %02h, expected %02h", $time, what, got, want);
      fail_count++;
   endtask

   function automatic logic [7:0] flash_reply(input logic [7:0] b);
      logic [7:0] reply;
      reply = 8'h00;
      case (cur_phase)
         PH_CMD: begin
            if (b == CMD_READ) cur_phase = PH_ADDR_HI;
            else cur_phase = PH_ERROR;
         end
         PH_ADDR_HI: begin
            cur_pointer = cur_pointer | {b, 16'h0000};
            cur_phase   = PH_ADDR_MID;
         end
         PH_ADDR_MID: begin
            cur_pointer = cur_pointer | {8'h00, b, 8'h00};
            cur_phase   = PH_ADDR_LO;
         end
         PH_ADDR_LO: begin
            cur_pointer = cur_pointer | {16'h0000, b};
            cur_phase   = PH_STREAM;
         end
         PH_STREAM: begin
            reply       = image_bytes[cur_pointer % IMAGE_DEPTH];
            cur_pointer = cur_pointer + 24'd1;
         end
         default: ;
      endcase
      return reply;
   endfunction

   function automatic void shift_to_device(input logic [7:0] b);
      if (cur_device == DEV_FLASH) last_byte = flash_reply(b);
      else if (cur_device == DEV_SDCARD || cur_device == DEV_RTC) last_byte = IDLE_BYTE;
   endfunction

   function automatic logic [7:0] predict_rdata(input logic [1:0] func,
                                                input logic [1:0] reg_addr,
                                                input logic [7:0] wdata,
                                                input logic [16:0] load_addr);
      logic [7:0] rd;
      rd = 8'h00;
      case (func)
         FUNC_READ: begin
            case (reg_addr)
               REG_CTRL: rd = {5'd0, cur_device};
               REG_DATA: begin
                  rd = last_byte;
                  shift_to_device(8'h00);
               end
               REG_PEEK: rd = last_byte;
               default: ;
            endcase
         end
         FUNC_WRITE: begin
            case (reg_addr)
               REG_CTRL: begin
                  if (wdata[2:0] == DEV_FLASH) begin
                     cur_device = DEV_FLASH;
                  end else begin
                     cur_phase   = PH_CMD;
                     cur_pointer = '0;
                     if (wdata[2:0] == DEV_SDCARD || wdata[2:0] == DEV_RTC)
                        cur_device = wdata[2:0];
                     else
                        cur_device = DEV_NONE;
                  end
               end
               REG_DATA: shift_to_device(wdata);
               default: ;
            endcase
         end
         FUNC_LOAD: image_bytes[load_addr % IMAGE_DEPTH] = wdata;
         default: ;
      endcase
      return rd;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         cur_device  = DEV_NONE;
         cur_phase   = PH_CMD;
         cur_pointer = '0;
         last_byte   = IDLE_BYTE;
         expected_rdata.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rdata.size() == 0) begin
               report_mismatch("response with no item waiting", rsp_rdata, 8'h00);
            end else begin
               oldest_rdata = expected_rdata.pop_front();
               if (rsp_rdata !== oldest_rdata)
                  report_mismatch("wrong rdata", rsp_rdata, oldest_rdata);
            end
         end
         if (req_valid && req_ready)
            expected_rdata.push_back(predict_rdata(req_func, req_reg_addr, req_wdata,
                                                   req_load_addr));
      end
      outstanding <= expected_rdata.size();
   end

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Drives bus reads, writes and image loads into the SPI port: a directed
// pass over the registers, device selects, flash command errors and pointer
// wrap, then random flash read bursts mixed with random noise items under
// several sender and receiver idling patterns. The checker gives the verdict.
// ---------------------------------------------------------------------------
module tb_top import spif_pkg::*; ();

   localparam int unsigned DEPTH           = IMAGE_DEPTH_DEF;
   localparam logic [1:0]  FUNC_NONE       = 2'd3;
   localparam logic [1:0]  REG_SPARE       = 2'd3;
   localparam int unsigned ITEMS_PER_PHASE = 400;
   localparam int unsigned HOLD_LEN        = 300;
   localparam int unsigned DRAIN_CYCLES    = 20;

   logic        clock         = 1'b0;
   logic        reset         = 1'b1;
   logic        req_valid     = 1'b0;
   logic        req_ready;
   logic [1:0]  req_func      = FUNC_READ;
   logic [1:0]  req_reg_addr  = REG_CTRL;
   logic [7:0]  req_wdata     = 8'h00;
   logic [16:0] req_load_addr = 17'h00000;
   logic        rsp_valid;
   logic        rsp_ready     = 1'b0;
   logic [7:0]  rsp_rdata;
   int unsigned outstanding;
   int unsigned fail_count;

   int unsigned req_idle_pct  = 0;
   int unsigned rsp_stall_pct = 0;
   bit          hold_armed    = 1'b0;
   int unsigned hold_cycles   = 0;
   int unsigned item_count    = 0;

   // stimulus-side view of the flash, so streaming never hits an unloaded byte
   logic [2:0]  trk_device  = DEV_NONE;
   phase_type   trk_phase   = PH_CMD;
   logic [23:0] trk_pointer = '0;
   bit          image_loaded [DEPTH];

   spi_port_with_serial_flash_read #(.IMAGE_DEPTH(DEPTH)) u_dut (.*);

   spi_flash_read_checker #(.IMAGE_DEPTH(DEPTH)) u_checker (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (hold_armed && hold_cycles < HOLD_LEN) begin
         rsp_ready   <= 1'b0;
         hold_cycles <= hold_cycles + 1;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   task automatic send_item(input logic [1:0] func, input logic [1:0] reg_addr,
                            input logic [7:0] wdata, input logic [16:0] load_addr);
      logic [1:0]  f;
      logic [7:0]  w;
      logic [16:0] la;
      logic [7:0]  shifted;
      bit          is_shift;
      f  = func;
      w  = wdata;
      la = load_addr;
      is_shift = (f == FUNC_READ || f == FUNC_WRITE) && reg_addr == REG_DATA &&
                 trk_device == DEV_FLASH;
      if (is_shift && trk_phase == PH_STREAM && !image_loaded[trk_pointer % DEPTH]) begin
         f        = FUNC_LOAD;
         la       = 17'(trk_pointer % DEPTH);
         is_shift = 1'b0;
      end
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_func      <= f;
      req_reg_addr  <= reg_addr;
      req_wdata     <= w;
      req_load_addr <= la;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      shifted = (f == FUNC_WRITE) ? w : 8'h00;
      if (f == FUNC_LOAD) begin
         image_loaded[la % DEPTH] = 1'b1;
      end else if (f == FUNC_WRITE && reg_addr == REG_CTRL) begin
         if (w[2:0] == DEV_FLASH) begin
            trk_device = DEV_FLASH;
         end else begin
            trk_phase   = PH_CMD;
            trk_pointer = '0;
            if (w[2:0] == DEV_SDCARD || w[2:0] == DEV_RTC) trk_device = w[2:0];
            else trk_device = DEV_NONE;
         end
      end else if (is_shift) begin
         case (trk_phase)
            PH_CMD: begin
               if (shifted == CMD_READ) trk_phase = PH_ADDR_HI;
               else trk_phase = PH_ERROR;
            end
            PH_ADDR_HI: begin
               trk_pointer = trk_pointer | {shifted, 16'h0000};
               trk_phase   = PH_ADDR_MID;
            end
            PH_ADDR_MID: begin
               trk_pointer = trk_pointer | {8'h00, shifted, 8'h00};
               trk_phase   = PH_ADDR_LO;
            end
            PH_ADDR_LO: begin
               trk_pointer = trk_pointer | {16'h0000, shifted};
               trk_phase   = PH_STREAM;
            end
            PH_STREAM: trk_pointer = trk_pointer + 24'd1;
            default: ;
         endcase
      end
      if (f != FUNC_NONE) item_count++;
   endtask

   // preload most of a window, select the flash cleanly, send a command (mostly read)
   // and address, then stream through the window with a mix of data and register accesses
   task automatic flash_burst();
      logic [23:0] start;
      logic [2:0]  off_code;
      int unsigned len;
      len = $urandom_range(1, 12);
      if ($urandom_range(0, 3) == 0) start = 24'hFFFFFF - 24'($urandom_range(0, 6));
      else start = 24'($urandom);
      for (int unsigned k = 0; k < len; k++)
         if ($urandom_range(0, 5) != 0)
            send_item(FUNC_LOAD, 2'($urandom_range(0, 3)), 8'($urandom),
                      17'((start + 24'(k)) % DEPTH));
      do off_code = 3'($urandom); while (off_code == DEV_FLASH);
      send_item(FUNC_WRITE, REG_CTRL, {5'($urandom), off_code}, 17'($urandom));
      send_item(FUNC_WRITE, REG_CTRL, {5'($urandom), DEV_FLASH}, 17'($urandom));
      if ($urandom_range(0, 9) == 0)
         send_item(FUNC_WRITE, REG_DATA, 8'($urandom), 17'($urandom));
      else
         send_item(FUNC_WRITE, REG_DATA, CMD_READ, 17'($urandom));
      send_item(FUNC_WRITE, REG_DATA, start[23:16], 17'($urandom));
      send_item(FUNC_WRITE, REG_DATA, start[15:8], 17'($urandom));
      send_item(FUNC_WRITE, REG_DATA, start[7:0], 17'($urandom));
      for (int unsigned k = 0; k < len; k++) begin
         case ($urandom_range(0, 5))
            0, 1: send_item(FUNC_WRITE, REG_DATA, 8'($urandom), 17'($urandom));
            2, 3: send_item(FUNC_READ, REG_DATA, 8'($urandom), 17'($urandom));
            4: send_item(FUNC_READ, REG_PEEK, 8'($urandom), 17'($urandom));
            default: send_item(FUNC_READ, REG_CTRL, 8'($urandom), 17'($urandom));
         endcase
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      int unsigned target;
      @(negedge reset);
      @(posedge clock);

      // reset values, idle registers, unused offset and function
      send_item(FUNC_READ, REG_CTRL, 8'h00, 17'h00000);
      send_item(FUNC_READ, REG_PEEK, 8'h00, 17'h00000);
      send_item(FUNC_READ, REG_DATA, 8'h00, 17'h00000);
      send_item(FUNC_READ, REG_SPARE, 8'hFF, 17'h1FFFF);
      send_item(FUNC_NONE, REG_SPARE, 8'hFF, 17'h1FFFF);
      // image ends, then read from the top of the 24-bit space to see the wrap
      send_item(FUNC_LOAD, REG_CTRL, 8'hA5, 17'h1FFFF);
      send_item(FUNC_LOAD, REG_SPARE, 8'h5A, 17'h00000);
      send_item(FUNC_WRITE, REG_CTRL, 8'hF9, 17'h1FFFF);
      send_item(FUNC_WRITE, REG_DATA, CMD_READ, 17'h00000);
      send_item(FUNC_WRITE, REG_DATA, 8'hFF, 17'h00000);
      send_item(FUNC_WRITE, REG_DATA, 8'hFF, 17'h00000);
      send_item(FUNC_WRITE, REG_DATA, 8'hFF, 17'h00000);
      send_item(FUNC_READ, REG_DATA, 8'h00, 17'h00000);
      send_item(FUNC_READ, REG_PEEK, 8'h00, 17'h00000);
      send_item(FUNC_WRITE, REG_DATA, 8'h00, 17'h00000);
      send_item(FUNC_READ, REG_PEEK, 8'h00, 17'h00000);
      // ignored writes
      send_item(FUNC_WRITE, REG_PEEK, 8'h77, 17'h00000);
      send_item(FUNC_WRITE, REG_SPARE, 8'hFF, 17'h1FFFF);
      // sd card and rtc
      send_item(FUNC_WRITE, REG_CTRL, {5'd0, DEV_SDCARD}, 17'h00000);
      send_item(FUNC_WRITE, REG_DATA, 8'h00, 17'h00000);
      send_item(FUNC_READ, REG_CTRL, 8'h00, 17'h00000);
      send_item(FUNC_WRITE, REG_CTRL, {5'd0, DEV_RTC}, 17'h00000);
      send_item(FUNC_READ, REG_DATA, 8'h00, 17'h00000);
      // bad flash command, error answers zero until deselect
      send_item(FUNC_WRITE, REG_CTRL, {5'd0, DEV_FLASH}, 17'h00000);
      send_item(FUNC_WRITE, REG_DATA, 8'h02, 17'h00000);
      send_item(FUNC_WRITE, REG_DATA, 8'hFF, 17'h00000);
      send_item(FUNC_READ, REG_DATA, 8'h00, 17'h00000);
      send_item(FUNC_WRITE, REG_CTRL, 8'h00, 17'h00000);
      send_item(FUNC_READ, REG_CTRL, 8'h00, 17'h00000);

      for (int unsigned idle_step = 0; idle_step < 4; idle_step++) begin
         case (idle_step)
            0: begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin req_idle_pct = 84; rsp_stall_pct = 0;  end
            2: begin req_idle_pct = 0;  rsp_stall_pct = 84; end
            default: begin req_idle_pct = 7; rsp_stall_pct = 7; end
         endcase
         target = item_count + ITEMS_PER_PHASE;
         while (item_count < target) begin
            if (idle_step == 0 && !hold_armed && item_count + 250 > target)
               hold_armed = 1'b1;
            if ($urandom_range(0, 3) != 0) begin
               flash_burst();
            end else begin
               repeat ($urandom_range(1, 4))
                  send_item(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                            8'($urandom), 17'($urandom));
            end
         end
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

### files.f
rtl/spif_pkg.sv
rtl/spif_ram.sv
rtl/spi_port_with_serial_flash_read.sv
sim/spi_flash_read_checker.sv
sim/tb_top.sv
